// ===== rtl/core/rgbhsl_pkg.sv =====
// Package for the 8-bit RGB to HSL converter: widths, constants, stage types.
// No dependencies; used by rgb_to_hsl_8bit_core.
`default_nettype none

package rgbhsl_pkg;

  // Channel and arithmetic widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = 9;
  localparam int unsigned NumW    = 16;
  localparam int unsigned HueW    = 11;
  localparam int unsigned DivSteps = 8;   // one quotient bit per stage
  localparam int unsigned PipeDepth = DivSteps + 4;

  // Hue sector offsets, in units of 255 per sixth of the circle
  localparam logic [HueW-1:0] HueOfsGreen = 11'd510;
  localparam logic [HueW-1:0] HueOfsBlue  = 11'd1020;
  localparam logic [HueW-1:0] HueOfsWrap  = 11'd1530;
  localparam logic [HueW-1:0] HueMax      = 11'd1530;

  // Saturation divisor folds around the mid sum
  localparam logic [SumW-1:0] SumMid  = 9'd255;
  localparam logic [SumW-1:0] SumFull = 9'd510;

  // x / 6 for x <= 1530: (x * 10923) >> 16
  localparam int unsigned     Div6RecipW = 14;
  localparam logic [Div6RecipW-1:0] Div6Recip = 14'd10923;
  localparam int unsigned     Div6Shift  = 16;
  localparam int unsigned     ProdW      = HueW + Div6RecipW;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // After max/min search
  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] d;
    logic [SumW-1:0]  sum;
    logic [ChanW-1:0] adiff;
    logic             neg;
    sector_e          sec;
    logic             gray;
  } front_t;

  // Two restoring dividers running side by side
  typedef struct packed {
    logic [NumW-1:0]  rem_s;
    logic [ChanW-1:0] den_s;
    logic [ChanW-1:0] quo_s;
    logic [NumW-1:0]  rem_h;
    logic [ChanW-1:0] den_h;
    logic [ChanW-1:0] quo_h;
    logic [ChanW-1:0] lig;
    logic [ChanW-1:0] gval;
    logic             neg;
    sector_e          sec;
    logic             gray;
  } div_t;

  // Hue before the divide by six
  typedef struct packed {
    logic [HueW-1:0]  hsum;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] lig;
    logic [ChanW-1:0] gval;
    logic             gray;
  } hsum_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsl_8bit_core.sv =====
// Stages in order: front, divider load, divide steps, hue sum, output; each is registered.
// Throughput: one pixel per cycle while out_ready_i does not stall; eight single-bit
// restoring divide stages (saturation and hue in parallel) set the depth.
// Each stage holds when its successor is full and stalled, so bubbles close up.
// Reset (rst_ni low, async) clears the stage valid bits only.
// Depends on rgbhsl_pkg.
`default_nettype none

module rgb_to_hsl_8bit_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] red_i,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] green_i,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] blue_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [rgbhsl_pkg::ChanW-1:0]      hue_o,
  output logic [rgbhsl_pkg::ChanW-1:0]      saturation_o,
  output logic [rgbhsl_pkg::ChanW-1:0]      lightness_o
);

  localparam int unsigned Depth = rgbhsl_pkg::PipeDepth;
  localparam int unsigned Steps = rgbhsl_pkg::DivSteps;
  localparam int unsigned CW    = rgbhsl_pkg::ChanW;

  // Stage map: 0 front, 1 divider load, 2..Steps+1 divide steps,
  // Steps+2 hue sum, Steps+3 output
  logic [Depth-1:0] v_q, v_d, v_in;
  logic [Depth:0]   rdy;

  // Per-stage ready: a stage takes data when empty or draining
  assign rdy[Depth] = out_ready_i;
  for (genvar k = 0; k < Depth; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  assign v_in = {v_q[Depth-2:0], in_valid_i};
  assign v_d  = (rdy[Depth-1:0] & v_in) | (~rdy[Depth-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Depth-1];

  // ---------------------------------------------------------------
  // Front: max/min search, sector pick, difference magnitude
  rgbhsl_pkg::front_t fr_d, fr_q;
  logic [CW-1:0] mx, mn, pa, pb;
  rgbhsl_pkg::sector_e sec;

  always_comb begin
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    // ties: red over green, green over blue
    if (red_i >= green_i && red_i >= blue_i) begin
      sec = rgbhsl_pkg::SEC_RED;
      mx  = red_i;
      pa  = green_i;
      pb  = blue_i;
    end else if (green_i >= blue_i) begin
      sec = rgbhsl_pkg::SEC_GREEN;
      mx  = green_i;
      pa  = blue_i;
      pb  = red_i;
    end else begin
      sec = rgbhsl_pkg::SEC_BLUE;
      mx  = blue_i;
      pa  = red_i;
      pb  = green_i;
    end
    fr_d.mx    = mx;
    fr_d.d     = mx - mn;
    fr_d.sum   = {1'b0, mx} + {1'b0, mn};
    fr_d.neg   = (pa < pb);
    fr_d.adiff = (pa < pb) ? (pb - pa) : (pa - pb);
    fr_d.sec   = sec;
    fr_d.gray  = (mx == mn);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      fr_q <= fr_d;
    end
  end

  // ---------------------------------------------------------------
  // Divider load: folded divisor, numerators scaled by 255
  rgbhsl_pkg::div_t div_q [0:Steps];
  rgbhsl_pkg::div_t div_d [0:Steps];
  logic [rgbhsl_pkg::SumW-1:0] den_fold;

  always_comb begin
    den_fold = (fr_q.sum > rgbhsl_pkg::SumMid) ? (rgbhsl_pkg::SumFull - fr_q.sum)
                                               : fr_q.sum;
    div_d[0].rem_s = {fr_q.d, 8'd0} - {8'd0, fr_q.d};
    div_d[0].den_s = den_fold[CW-1:0];
    div_d[0].quo_s = '0;
    div_d[0].rem_h = {fr_q.adiff, 8'd0} - {8'd0, fr_q.adiff};
    div_d[0].den_h = fr_q.d;
    div_d[0].quo_h = '0;
    div_d[0].lig   = fr_q.sum[rgbhsl_pkg::SumW-1:1];
    div_d[0].gval  = fr_q.mx;
    div_d[0].neg   = fr_q.neg;
    div_d[0].sec   = fr_q.sec;
    div_d[0].gray  = fr_q.gray;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      div_q[0] <= div_d[0];
    end
  end

  // ---------------------------------------------------------------
  // Divide steps: stage j settles quotient bit Steps-j of both dividers.
  // Both quotients are known to fit in eight bits.
  for (genvar j = 1; j <= Steps; j++) begin : g_div
    localparam int unsigned BitK = Steps - j;
    logic [rgbhsl_pkg::NumW:0] trial_s, trial_h;

    always_comb begin
      div_d[j] = div_q[j-1];
      trial_s  = {1'b0, div_q[j-1].rem_s}
               - ((rgbhsl_pkg::NumW+1)'(div_q[j-1].den_s) << BitK);
      trial_h  = {1'b0, div_q[j-1].rem_h}
               - ((rgbhsl_pkg::NumW+1)'(div_q[j-1].den_h) << BitK);
      if (!trial_s[rgbhsl_pkg::NumW]) begin
        div_d[j].rem_s       = trial_s[rgbhsl_pkg::NumW-1:0];
        div_d[j].quo_s[BitK] = 1'b1;
      end
      if (!trial_h[rgbhsl_pkg::NumW]) begin
        div_d[j].rem_h       = trial_h[rgbhsl_pkg::NumW-1:0];
        div_d[j].quo_h[BitK] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+1]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // ---------------------------------------------------------------
  // Hue sum: sector offset plus signed quotient (truncated toward zero)
  rgbhsl_pkg::hsum_t hs_d, hs_q;
  logic [rgbhsl_pkg::HueW-1:0] qh;

  always_comb begin
    qh = rgbhsl_pkg::HueW'(div_q[Steps].quo_h);
    case (div_q[Steps].sec)
      rgbhsl_pkg::SEC_RED:   hs_d.hsum = div_q[Steps].neg ? (rgbhsl_pkg::HueOfsWrap - qh) : qh;
      rgbhsl_pkg::SEC_GREEN: hs_d.hsum = div_q[Steps].neg ? (rgbhsl_pkg::HueOfsGreen - qh)
                                                          : (rgbhsl_pkg::HueOfsGreen + qh);
      rgbhsl_pkg::SEC_BLUE:  hs_d.hsum = div_q[Steps].neg ? (rgbhsl_pkg::HueOfsBlue - qh)
                                                          : (rgbhsl_pkg::HueOfsBlue + qh);
      default:               hs_d.hsum = '0;
    endcase
    hs_d.sat  = div_q[Steps].quo_s;
    hs_d.lig  = div_q[Steps].lig;
    hs_d.gval = div_q[Steps].gval;
    hs_d.gray = div_q[Steps].gray;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Steps+2]) begin
      hs_q <= hs_d;
    end
  end

  // ---------------------------------------------------------------
  // Output: divide by six via reciprocal multiply, gray override
  logic [rgbhsl_pkg::ProdW-1:0] prod;
  logic [CW-1:0] hue_d, sat_d, lig_d;
  logic [CW-1:0] hue_q, sat_q, lig_q;

  always_comb begin
    prod  = rgbhsl_pkg::ProdW'(hs_q.hsum) * rgbhsl_pkg::ProdW'(rgbhsl_pkg::Div6Recip);
    hue_d = hs_q.gray ? hs_q.gval : prod[rgbhsl_pkg::Div6Shift +: CW];
    sat_d = hs_q.gray ? '0 : hs_q.sat;
    lig_d = hs_q.gray ? hs_q.gval : hs_q.lig;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Steps+3]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      lig_q <= lig_d;
    end
  end

  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign lightness_o  = lig_q;

  // ---------------------------------------------------------------
  // Checks

  // full pipe with a stalled result must refuse new requests
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !out_ready_i) |-> !in_ready_o)
    else $error("request accepted into a full stalled pipeline");

  // restoring divider leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Steps+1] && !div_q[Steps].gray) |->
      (div_q[Steps].rem_s < {8'd0, div_q[Steps].den_s}) &&
      (div_q[Steps].rem_h < {8'd0, div_q[Steps].den_h}))
    else $error("divider remainder not below divisor");

  // hue sum stays within one turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Steps+2] && !hs_q.gray) |-> (hs_q.hsum <= rgbhsl_pkg::HueMax))
    else $error("hue sum out of range");

endmodule

`default_nettype wire

// ===== sim/hsl_pixel_checker.sv =====
// Checker for rgb_to_hsl_8bit_core: predicts the HSL value of every accepted
// RGB request and compares it with the results in order. Depends on rgbhsl_pkg.
`timescale 1ns / 1ps

module hsl_pixel_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] red_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] green_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] blue_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] hue_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] saturation_i,
  input  logic [rgbhsl_pkg::ChanW-1:0] lightness_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  hsl_due_cnt_o
);

  typedef struct packed {
    logic [rgbhsl_pkg::ChanW-1:0] hue;
    logic [rgbhsl_pkg::ChanW-1:0] sat;
    logic [rgbhsl_pkg::ChanW-1:0] light;
  } hsl_pix_t;

  hsl_pix_t hsl_due_q[$];
  hsl_pix_t hsl_want;

  // Integer HSL of one pixel; hue quotient truncates toward zero
  function automatic hsl_pix_t hsl_of_rgb(input logic [rgbhsl_pkg::ChanW-1:0] r,
                                          input logic [rgbhsl_pkg::ChanW-1:0] g,
                                          input logic [rgbhsl_pkg::ChanW-1:0] b);
    int                  rv, gv, bv, mx, mn, d, sum, fold, den, h;
    rgbhsl_pkg::sector_e sec;
    hsl_pix_t            p;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    // ties: red beats green, green beats blue
    if (rv >= gv && rv >= bv) begin
      sec = rgbhsl_pkg::SEC_RED;
      mx  = rv;
    end else if (gv >= bv) begin
      sec = rgbhsl_pkg::SEC_GREEN;
      mx  = gv;
    end else begin
      sec = rgbhsl_pkg::SEC_BLUE;
      mx  = bv;
    end
    mn = (rv < gv) ? rv : gv;
    mn = (mn < bv) ? mn : bv;
    // gray pixel: hue carries the gray level
    if (mx == mn) begin
      p.hue   = mx[rgbhsl_pkg::ChanW-1:0];
      p.sat   = '0;
      p.light = mx[rgbhsl_pkg::ChanW-1:0];
      return p;
    end
    d    = mx - mn;
    sum  = mx + mn;
    fold = (sum > 255) ? sum - 255 : 255 - sum;
    den  = 255 - fold;
    case (sec)
      rgbhsl_pkg::SEC_RED:   h = (255 * (gv - bv)) / d + ((gv < bv) ? 255 * 6 : 0);
      rgbhsl_pkg::SEC_GREEN: h = (255 * (bv - rv)) / d + 255 * 2;
      default:               h = (255 * (rv - gv)) / d + 255 * 4;
    endcase
    h       = h / 6;
    p.hue   = h[rgbhsl_pkg::ChanW-1:0];
    fold    = (255 * d) / den;
    p.sat   = fold[rgbhsl_pkg::ChanW-1:0];
    sum     = sum / 2;
    p.light = sum[rgbhsl_pkg::ChanW-1:0];
    return p;
  endfunction

  // Compare accepted results first, then queue the new request's prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (hsl_due_q.size() == 0) begin
          $error("result with no request pending: hue %0d saturation %0d lightness %0d",
                 hue_i, saturation_i, lightness_i);
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          hsl_want = hsl_due_q.pop_front();
          if (hue_i !== hsl_want.hue) begin
            $error("hue: expected %0d, actual %0d", hsl_want.hue, hue_i);
            mismatch_cnt_o = mismatch_cnt_o + 1;
          end
          if (saturation_i !== hsl_want.sat) begin
            $error("saturation: expected %0d, actual %0d", hsl_want.sat, saturation_i);
            mismatch_cnt_o = mismatch_cnt_o + 1;
          end
          if (lightness_i !== hsl_want.light) begin
            $error("lightness: expected %0d, actual %0d", hsl_want.light, lightness_i);
            mismatch_cnt_o = mismatch_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        hsl_due_q.push_back(hsl_of_rgb(red_i, green_i, blue_i));
      end
      hsl_due_cnt_o = hsl_due_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the rgb_to_hsl_8bit_core testbench: clock, reset, pixel requests and
// result back-pressure. Depends on rgbhsl_pkg, the core and hsl_pixel_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NumRandom   = 2000;
  localparam int unsigned LongHoldCyc = 80;
  localparam int unsigned TailCyc     = 40;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic [rgbhsl_pkg::ChanW-1:0] red = '0;
  logic [rgbhsl_pkg::ChanW-1:0] green = '0;
  logic [rgbhsl_pkg::ChanW-1:0] blue = '0;
  logic                         out_ready = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [rgbhsl_pkg::ChanW-1:0] hue;
  logic [rgbhsl_pkg::ChanW-1:0] saturation;
  logic [rgbhsl_pkg::ChanW-1:0] lightness;

  int unsigned mismatch_cnt;
  int unsigned hsl_due_cnt;

  // Flags owned by the request process, read by the result side
  logic quiet = 1'b0;
  logic long_hold_go = 1'b0;

  logic [3*rgbhsl_pkg::ChanW-1:0] directed_px[$];

  rgb_to_hsl_8bit_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hue_o        (hue),
    .saturation_o (saturation),
    .lightness_o  (lightness)
  );

  hsl_pixel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .hue_i          (hue),
    .saturation_i   (saturation),
    .lightness_i    (lightness),
    .mismatch_cnt_o (mismatch_cnt),
    .hsl_due_cnt_o  (hsl_due_cnt)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one pixel from the falling edge and hold it until accepted
  task automatic send_pixel(input logic [rgbhsl_pkg::ChanW-1:0] r,
                            input logic [rgbhsl_pkg::ChanW-1:0] g,
                            input logic [rgbhsl_pkg::ChanW-1:0] b);
    int unsigned gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk_i); while (!in_ready);
    // random idle burst between requests
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid <= 1'b0;
      red      <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (hsl_due_cnt != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    logic        long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LongHoldCyc - 1) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Request stream and verdict
  initial begin
    logic [rgbhsl_pkg::ChanW-1:0] r, g, b, base;
    logic [rgbhsl_pkg::ChanW-1:0] corner[4];
    int unsigned                  lo, hi;
    corner = '{8'd0, 8'd1, 8'd254, 8'd255};
    // extremes, primaries, max ties, red wrap, unit divisor at both ends
    directed_px = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hC8C832,
                    24'h32C8C8, 24'hC832C8, 24'hC80A64, 24'hC8640A, 24'h0AC864,
                    24'h640AC8, 24'h010000, 24'hFFFEFE, 24'hFF0001, 24'h807F7F,
                    24'h7F8080, 24'hAA5500, 24'h0055AA, 24'hFF8000};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_px[i]) begin
      send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 500) long_hold_go <= 1'b1;
      if (n == 1000) wait_drained();
      if (n == NumRandom - 300) quiet <= 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          // gray
          r = 8'($urandom);
          g = r;
          b = r;
        end
        1: begin
          // two channels tied
          r = 8'($urandom);
          g = r;
          b = 8'($urandom);
          case ($urandom_range(0, 2))
            0: ;
            1: begin g = b; b = r; end
            default: begin b = r; r = g; g = 8'($urandom); end
          endcase
        end
        2: begin
          // near-gray around a base level: tiny d and tiny divisors
          base = 8'($urandom);
          lo = (base < 3) ? 0 : base - 3;
          hi = (base > 252) ? 255 : base + 3;
          r = 8'($urandom_range(lo, hi));
          g = 8'($urandom_range(lo, hi));
          b = 8'($urandom_range(lo, hi));
        end
        3: begin
          r = corner[$urandom_range(0, 3)];
          g = corner[$urandom_range(0, 3)];
          b = corner[$urandom_range(0, 3)];
        end
        default: begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      send_pixel(r, g, b);
    end

    wait_drained();
    repeat (TailCyc) @(negedge clk_i);
    if (mismatch_cnt == 0 && hsl_due_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
